[sv/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the packet header checksum filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define HCF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");
// Next-cycle implication, disabled during reset.
`define HCF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");
`else
`define HCF_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define HCF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[sv/hcf_pkg.sv]
// Shared types and constants of the packet header checksum filter.
package hcf_pkg;

  localparam int unsigned MAX_PACKET_BYTES = 4096;
  localparam int unsigned HEADER_BYTES     = 8;
  localparam int unsigned CFG_INDEX_W      = 3;
  localparam int unsigned CFG_DATA_W       = 16;
  localparam logic [7:0]  SENS_MASK        = 8'h40;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MAGIC_VALUE         = 3'd0,
    CFG_MIN_LENGTH          = 3'd1,
    CFG_FIRST_WORD_TERM     = 3'd2,
    CFG_CHECKSUM_FIELD_TERM = 3'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    VERDICT_FORWARD      = 3'd0,
    VERDICT_TOO_SHORT    = 3'd1,
    VERDICT_BAD_MAGIC    = 3'd2,
    VERDICT_LEN_MISMATCH = 3'd3,
    VERDICT_CSUM_FAIL    = 3'd4
  } verdict_t;

  // Snapshot of one finished packet, handed from the accumulator to the verdict stage.
  typedef struct packed {
    logic [15:0] running_sum;
    logic [7:0]  pending_high_byte;
    logic [15:0] header_length;
    logic [15:0] stored_checksum;
    logic        magic_ok;
    logic        sensitive_flag;
  } fin_t;

endpackage

[sv/hcf_accum.sv]
// Per-byte header capture and running ones' complement sum, with a finished-packet register.
module hcf_accum #(
  parameter int unsigned MaxBytes = hcf_pkg::MAX_PACKET_BYTES,
  parameter int unsigned CountW   = $clog2(MaxBytes + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              pkt_end,
  input  logic [7:0]        magic_value,
  input  logic              fin_take,
  output logic              fin_valid,
  output hcf_pkg::fin_t     fin,
  output logic [CountW-1:0] fin_count
);
  import hcf_pkg::*;

  logic [CountW-1:0] byte_count, byte_count_next;
  logic              magic_ok, magic_ok_next;
  logic              sensitive_flag, sensitive_flag_next;
  logic [15:0]       header_length, header_length_next;
  logic [15:0]       stored_checksum, stored_checksum_next;
  logic [15:0]       running_sum, running_sum_next;
  logic [7:0]        pending_high_byte, pending_high_byte_next;
  logic [16:0]       word_sum;

  assign word_sum = {1'b0, running_sum} + {1'b0, pending_high_byte, data_byte};

  always_comb begin
    byte_count_next        = byte_count;
    magic_ok_next          = magic_ok;
    sensitive_flag_next    = sensitive_flag;
    header_length_next     = header_length;
    stored_checksum_next   = stored_checksum;
    running_sum_next       = running_sum;
    pending_high_byte_next = pending_high_byte;
    if (byte_count < CountW'(MaxBytes)) begin
      byte_count_next = byte_count + 1'b1;
      priority if (byte_count == CountW'(0)) begin
        magic_ok_next = (data_byte == magic_value);
      end else if (byte_count == CountW'(1)) begin
        sensitive_flag_next = |(data_byte & SENS_MASK);
      end else if (byte_count == CountW'(2)) begin
        header_length_next[15:8] = data_byte;
      end else if (byte_count == CountW'(3)) begin
        header_length_next[7:0] = data_byte;
      end else if (byte_count == CountW'(4)) begin
        stored_checksum_next[15:8] = data_byte;
      end else if (byte_count == CountW'(5)) begin
        stored_checksum_next[7:0] = data_byte;
      end else if (byte_count >= CountW'(HEADER_BYTES)) begin
        // Header length is even, so payload word parity is the count's low bit.
        if (!byte_count[0]) begin
          pending_high_byte_next = data_byte;
        end else begin
          running_sum_next = word_sum[15:0] + 16'(word_sum[16]);
        end
      end else begin
        byte_count_next = byte_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count        <= '0;
      magic_ok          <= 1'b0;
      sensitive_flag    <= 1'b0;
      header_length     <= '0;
      stored_checksum   <= '0;
      running_sum       <= '0;
      pending_high_byte <= '0;
      fin_valid         <= 1'b0;
    end else begin
      if (accept && pkt_end) begin
        byte_count        <= '0;
        magic_ok          <= 1'b0;
        sensitive_flag    <= 1'b0;
        header_length     <= '0;
        stored_checksum   <= '0;
        running_sum       <= '0;
        pending_high_byte <= '0;
        fin_valid         <= 1'b1;
      end else begin
        if (accept) begin
          byte_count        <= byte_count_next;
          magic_ok          <= magic_ok_next;
          sensitive_flag    <= sensitive_flag_next;
          header_length     <= header_length_next;
          stored_checksum   <= stored_checksum_next;
          running_sum       <= running_sum_next;
          pending_high_byte <= pending_high_byte_next;
        end
        if (fin_take) begin
          fin_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pkt_end) begin
      fin_count                 <= byte_count_next;
      fin.running_sum           <= running_sum_next;
      fin.pending_high_byte     <= pending_high_byte_next;
      fin.header_length         <= header_length_next;
      fin.stored_checksum       <= stored_checksum_next;
      fin.magic_ok              <= magic_ok_next;
      fin.sensitive_flag        <= sensitive_flag_next;
    end
  end

endmodule

[sv/hcf_verdict.sv]
// Checksum closing sum, ordered packet checks and the result register.
module hcf_verdict #(
  parameter int unsigned MaxBytes = hcf_pkg::MAX_PACKET_BYTES,
  parameter int unsigned CountW   = $clog2(MaxBytes + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fin_take,
  input  hcf_pkg::fin_t     fin,
  input  logic [CountW-1:0] fin_count,
  input  logic [15:0]       min_length,
  input  logic [15:0]       first_word_term,
  input  logic [15:0]       checksum_field_term,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [2:0]        verdict,
  output logic [CountW-1:0] packet_length,
  output logic              sensitive,
  output logic [15:0]       result_checksum
);
  import hcf_pkg::*;

  localparam int unsigned ExtW = ((CountW > 16) ? CountW : 16) + 1;

  logic [15:0]     pad_word;
  logic [18:0]     total;
  logic [16:0]     fold1;
  logic [15:0]     fold2;
  logic [15:0]     chk;
  logic [ExtW-1:0] n_ext;
  logic [ExtW-1:0] len_plus_hdr;
  verdict_t        verdict_next;

  // Pad an odd trailing payload byte low.
  assign pad_word = (fin_count >= CountW'(HEADER_BYTES) && fin_count[0]) ?
                    {fin.pending_high_byte, 8'h00} : 16'h0000;

  // Five-term sum, then fold the carries back twice (end-around carry).
  assign total = 19'(fin.running_sum) + 19'(pad_word) + 19'(first_word_term)
               + 19'(fin.header_length) + 19'(checksum_field_term);
  assign fold1 = 17'(total[15:0]) + 17'(total[18:16]);
  assign fold2 = fold1[15:0] + 16'(fold1[16]);
  assign chk   = ~fold2;

  assign n_ext        = ExtW'(fin_count);
  assign len_plus_hdr = ExtW'(fin.header_length) + ExtW'(HEADER_BYTES);

  always_comb begin
    priority if (n_ext < ExtW'(min_length)) begin
      verdict_next = VERDICT_TOO_SHORT;
    end else if (!fin.magic_ok) begin
      verdict_next = VERDICT_BAD_MAGIC;
    end else if (fin_count >= CountW'(MaxBytes) || n_ext < ExtW'(HEADER_BYTES) ||
                 len_plus_hdr != n_ext) begin
      verdict_next = VERDICT_LEN_MISMATCH;
    end else if (fin.sensitive_flag && chk != fin.stored_checksum) begin
      verdict_next = VERDICT_CSUM_FAIL;
    end else begin
      verdict_next = VERDICT_FORWARD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_take) begin
      verdict         <= verdict_next;
      packet_length   <= fin_count;
      sensitive       <= fin.sensitive_flag;
      result_checksum <= chk;
    end
  end

endmodule

[sv/packet_header_checksum_filter.sv]
// After its last byte transfer, a packet's verdict passes through the finished-packet register
// and then the result register, and either one holds while the output is stalled.
// Throughput: one byte per clock; the input stalls only while the finished-packet register
// and the result register both hold a packet and the output is stalled.
// Reset (rst, synchronous, active high): clears the packet state, empties both result
// stages and loads the configuration defaults (magic 0, min_length 8, sum terms 0).
`include "assert_macros.svh"

module packet_header_checksum_filter #(
  parameter int unsigned MaxBytes = hcf_pkg::MAX_PACKET_BYTES,
  parameter int unsigned CountW   = $clog2(MaxBytes + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  // byte input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     data_byte,
  input  logic                           pkt_end,
  // verdict output channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     verdict,
  output logic [CountW-1:0]              packet_length,
  output logic                           sensitive,
  output logic [15:0]                    result_checksum,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hcf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hcf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import hcf_pkg::*;

  logic [7:0]        magic_value;
  logic [15:0]       min_length;
  logic [15:0]       first_word_term;
  logic [15:0]       checksum_field_term;

  logic              in_accept;
  logic              fin_valid;
  logic              fin_take;
  fin_t              fin;
  logic [CountW-1:0] fin_count;

  // Configuration is always writable; unknown indexes drop the transfer.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_value         <= '0;
      min_length          <= 16'(HEADER_BYTES);
      first_word_term     <= '0;
      checksum_field_term <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAGIC_VALUE:         magic_value         <= cfg_data[7:0];
        CFG_MIN_LENGTH:          min_length          <= cfg_data;
        CFG_FIRST_WORD_TERM:     first_word_term     <= cfg_data;
        CFG_CHECKSUM_FIELD_TERM: checksum_field_term <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the finished packet whenever the result register is empty or being drained.
  assign fin_take  = fin_valid && (!out_valid || !out_stall);
  // Hold the input only when a finished packet cannot move on.
  assign in_stall  = fin_valid && !fin_take;
  assign in_accept = in_valid && !in_stall;

  hcf_accum #(
    .MaxBytes (MaxBytes),
    .CountW   (CountW)
  ) u_accum (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_accept),
    .data_byte   (data_byte),
    .pkt_end     (pkt_end),
    .magic_value (magic_value),
    .fin_take    (fin_take),
    .fin_valid   (fin_valid),
    .fin         (fin),
    .fin_count   (fin_count)
  );

  hcf_verdict #(
    .MaxBytes (MaxBytes),
    .CountW   (CountW)
  ) u_verdict (
    .clk                 (clk),
    .rst                 (rst),
    .fin_take            (fin_take),
    .fin                 (fin),
    .fin_count           (fin_count),
    .min_length          (min_length),
    .first_word_term     (first_word_term),
    .checksum_field_term (checksum_field_term),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .verdict             (verdict),
    .packet_length       (packet_length),
    .sensitive           (sensitive),
    .result_checksum     (result_checksum)
  );

  // The input is held back only by a finished packet waiting on the output.
  `HCF_ASSERT_IMPLY(a_stall_needs_fin, clk, rst, in_stall, fin_valid)
  // A finished packet that moves on always shows up as a result.
  `HCF_ASSERT_NEXT(a_take_fills_out, clk, rst, fin_take, out_valid)
  // A forwarded packet has a full header and an unsaturated count.
  `HCF_ASSERT_IMPLY(a_forward_len_sane, clk, rst,
                    out_valid && verdict == VERDICT_FORWARD,
                    packet_length >= CountW'(HEADER_BYTES) && packet_length < CountW'(MaxBytes))

endmodule
